[rtl/dct_pkg.sv]
// ============================================================================
// dct_pkg: shared types and constants for the divisor counter
// Holds field widths, the limit at reset, the primality bases, the
// shared-unit operation codes and the sequencer states.
// ============================================================================
`default_nettype none

package dct_pkg;

    localparam int NUM_WIDTH_DEF = 64;
    localparam int IN_W          = 64;
    localparam int LIMIT_W       = 64;
    localparam int TOTAL_W       = 17;
    localparam int OUT_TDATA_W   = 24;

    localparam logic [LIMIT_W-1:0] LIMIT_RESET = 64'd9999999999999999;

    // Bases of the strong probable-prime test; together they decide every
    // 64-bit number exactly.
    localparam int MR_NUM_BASES = 12;
    localparam int BASE_W       = 6;
    localparam logic [BASE_W-1:0] MR_BASES [MR_NUM_BASES] = '{
        6'd2, 6'd3, 6'd5, 6'd7, 6'd11, 6'd13, 6'd17, 6'd19, 6'd23, 6'd29, 6'd31, 6'd37
    };

    typedef enum logic [1:0] {
        ALU_DIV,
        ALU_MULMOD,
        ALU_SQRT
    } alu_op_t;

    typedef struct packed {
        logic    start;
        alu_op_t op;
    } alu_req_t;

    typedef enum logic [4:0] {
        ST_IDLE,
        ST_CHECK,
        ST_TRIAL_ISSUE,
        ST_TRIAL_WAIT,
        ST_FOLD,
        ST_REM,
        ST_BASE_CHECK,
        ST_BASE_WAIT,
        ST_MR_SETUP,
        ST_MR_SHIFT,
        ST_MR_BASE,
        ST_MR_SQ,
        ST_MR_SQ_WAIT,
        ST_MR_MUL,
        ST_MR_MUL_WAIT,
        ST_MR_TEST,
        ST_MR_LOOP,
        ST_MR_LOOP_WAIT,
        ST_SQRT_ISSUE,
        ST_SQRT_WAIT,
        ST_DONE
    } ctrl_state_t;

endpackage

`default_nettype wire

[rtl/dct_alu.sv]
// ============================================================================
// dct_alu: shared bit-serial arithmetic unit
// One compare-and-subtract datapath, reused for restoring division,
// shift-and-add modular multiplication and digit-by-digit square root.
// ============================================================================
`default_nettype none

module dct_alu #(
    parameter int NUM_WIDTH = dct_pkg::NUM_WIDTH_DEF
) (
    input  wire logic                 clk,
    input  wire logic                 rst_n,
    input  wire dct_pkg::alu_req_t    req,
    input  wire logic [NUM_WIDTH-1:0] opa,
    input  wire logic [NUM_WIDTH-1:0] opb,
    input  wire logic [NUM_WIDTH-1:0] opm,
    output logic                      done,
    output logic [NUM_WIDTH-1:0]      res_q,
    output logic [NUM_WIDTH-1:0]      res_r
);
    import dct_pkg::*;

    localparam int DW    = NUM_WIDTH + (NUM_WIDTH % 2);
    localparam int HW    = DW / 2;
    localparam int CNT_W = $clog2(DW + 1);

    logic              busy_reg, busy_next;
    logic              done_reg, done_next;
    logic              phase_reg, phase_next;
    alu_op_t           op_reg, op_next;
    logic [CNT_W-1:0]  cnt_reg, cnt_next;
    logic [DW-1:0]     sh_reg, sh_next;
    logic [DW-1:0]     acc_reg, acc_next;
    logic [DW-1:0]     sub_reg, sub_next;
    logic [DW-1:0]     add_reg, add_next;
    logic [HW-1:0]     root_reg, root_next;

    logic [DW-1:0]     addend;
    logic [DW+1:0]     cand;
    logic [DW+1:0]     subtr;
    logic [DW+1:0]     diff;
    logic              ge;
    logic [DW-1:0]     step_rem;
    logic              last;

    // Multiply: even phase doubles the accumulator, odd phase adds the
    // multiplicand when the current multiplier bit is set.
    assign addend = phase_reg ? (sh_reg[DW-1] ? add_reg : '0) : acc_reg;

    always_comb
    begin
        cand  = '0;
        subtr = {2'b00, sub_reg};
        unique case (op_reg)
            ALU_DIV:    cand = {1'b0, acc_reg, sh_reg[DW-1]};
            ALU_MULMOD: cand = {2'b00, acc_reg} + {2'b00, addend};
            ALU_SQRT:
            begin
                cand  = {acc_reg, sh_reg[DW-1 -: 2]};
                subtr = (DW+2)'({root_reg, 2'b01});
            end
            default:    cand = '0;
        endcase
    end

    assign ge       = (cand >= subtr);
    assign diff     = cand - subtr;
    assign step_rem = ge ? diff[DW-1:0] : cand[DW-1:0];
    assign last     = (cnt_reg == CNT_W'(1));

    always_comb
    begin
        busy_next  = busy_reg;
        done_next  = 1'b0;
        phase_next = phase_reg;
        op_next    = op_reg;
        cnt_next   = cnt_reg;
        sh_next    = sh_reg;
        acc_next   = acc_reg;
        sub_next   = sub_reg;
        add_next   = add_reg;
        root_next  = root_reg;
        if (busy_reg)
        begin
            acc_next = step_rem;
            unique case (op_reg)
                ALU_DIV:
                begin
                    sh_next  = {sh_reg[DW-2:0], ge};
                    cnt_next = cnt_reg - CNT_W'(1);
                    if (last)
                    begin
                        busy_next = 1'b0;
                        done_next = 1'b1;
                    end
                end
                ALU_MULMOD:
                begin
                    phase_next = !phase_reg;
                    if (phase_reg)
                    begin
                        sh_next  = {sh_reg[DW-2:0], 1'b0};
                        cnt_next = cnt_reg - CNT_W'(1);
                        if (last)
                        begin
                            busy_next = 1'b0;
                            done_next = 1'b1;
                        end
                    end
                end
                ALU_SQRT:
                begin
                    sh_next   = {sh_reg[DW-3:0], 2'b00};
                    root_next = {root_reg[HW-2:0], ge};
                    cnt_next  = cnt_reg - CNT_W'(1);
                    if (last)
                    begin
                        busy_next = 1'b0;
                        done_next = 1'b1;
                    end
                end
                default: busy_next = 1'b0;
            endcase
        end
        else if (req.start)
        begin
            busy_next  = 1'b1;
            op_next    = req.op;
            phase_next = 1'b0;
            acc_next   = '0;
            root_next  = '0;
            sub_next   = DW'((req.op == ALU_DIV) ? opb : opm);
            add_next   = DW'(opa);
            sh_next    = DW'((req.op == ALU_MULMOD) ? opb : opa);
            cnt_next   = (req.op == ALU_SQRT) ? CNT_W'(HW) : CNT_W'(DW);
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg  <= 1'b0;
            done_reg  <= 1'b0;
            phase_reg <= 1'b0;
            op_reg    <= ALU_DIV;
            cnt_reg   <= '0;
        end
        else
        begin
            busy_reg  <= busy_next;
            done_reg  <= done_next;
            phase_reg <= phase_next;
            op_reg    <= op_next;
            cnt_reg   <= cnt_next;
        end
    end

    always_ff @(posedge clk)
    begin
        sh_reg   <= sh_next;
        acc_reg  <= acc_next;
        sub_reg  <= sub_next;
        add_reg  <= add_next;
        root_reg <= root_next;
    end

    assign done  = done_reg;
    assign res_q = NUM_WIDTH'((op_reg == ALU_SQRT) ? DW'(root_reg) : sh_reg);
    assign res_r = NUM_WIDTH'(acc_reg);

endmodule

`default_nettype wire

[rtl/dct_ctrl.sv]
// ============================================================================
// dct_ctrl: sequencer of the divisor counter
// Trial division up to the cube root, then a small-base check, a strong
// probable-prime test and a square test of the cofactor that is left.
// ============================================================================
`default_nettype none

module dct_ctrl #(
    parameter int NUM_WIDTH = dct_pkg::NUM_WIDTH_DEF
) (
    input  wire logic                         clk,
    input  wire logic                         rst_n,
    input  wire logic                         in_valid,
    output logic                              in_ready,
    input  wire logic [dct_pkg::IN_W-1:0]     number,
    input  wire logic [dct_pkg::LIMIT_W-1:0]  upper_limit,
    output logic                              res_valid,
    input  wire logic                         out_free,
    output logic [dct_pkg::TOTAL_W-1:0]       res_total,
    output logic                              res_too_large,
    output dct_pkg::alu_req_t                 alu_req,
    output logic [NUM_WIDTH-1:0]              alu_a,
    output logic [NUM_WIDTH-1:0]              alu_b,
    output logic [NUM_WIDTH-1:0]              alu_m,
    input  wire logic                         alu_done,
    input  wire logic [NUM_WIDTH-1:0]         alu_q,
    input  wire logic [NUM_WIDTH-1:0]         alu_r
);
    import dct_pkg::*;

    localparam int P_W   = NUM_WIDTH / 3 + 2;
    localparam int CW    = NUM_WIDTH + 3;
    localparam int EXP_W = $clog2(NUM_WIDTH + 1);
    localparam int BIT_W = $clog2(NUM_WIDTH);
    localparam int IDX_W = $clog2(MR_NUM_BASES);
    localparam logic [IDX_W-1:0] LAST_IDX = IDX_W'(MR_NUM_BASES - 1);

    ctrl_state_t          state_reg, state_next;
    logic [NUM_WIDTH-1:0] n_reg, n_next;
    logic [P_W-1:0]       p_reg, p_next;
    logic [CW-1:0]        cube_reg, cube_next;
    logic [CW-1:0]        d1_reg, d1_next;
    logic [CW-1:0]        e1_reg, e1_next;
    logic [EXP_W-1:0]     exp_reg, exp_next;
    logic [TOTAL_W-1:0]   total_reg, total_next;
    logic                 flag_reg, flag_next;
    logic [IDX_W-1:0]     idx_reg, idx_next;
    logic [NUM_WIDTH-1:0] d_reg, d_next;
    logic [EXP_W-1:0]     s_reg, s_next;
    logic [NUM_WIDTH-1:0] x_reg, x_next;
    logic [BIT_W-1:0]     bit_reg, bit_next;
    logic [EXP_W-1:0]     rcnt_reg, rcnt_next;

    logic [NUM_WIDTH-1:0] n_in;
    logic [NUM_WIDTH-1:0] nm1;
    logic [NUM_WIDTH-1:0] base_val;
    logic [EXP_W:0]       fold_factor;
    logic [TOTAL_W-1:0]   total_x2;
    logic [TOTAL_W-1:0]   total_x3;
    logic [TOTAL_W-1:0]   total_x4;

    assign n_in        = number[NUM_WIDTH-1:0];
    assign nm1         = n_reg - NUM_WIDTH'(1);
    assign base_val    = NUM_WIDTH'(MR_BASES[idx_reg]);
    assign fold_factor = (EXP_W+1)'(exp_reg) + (EXP_W+1)'(1);
    assign total_x2    = {total_reg[TOTAL_W-2:0], 1'b0};
    assign total_x3    = total_reg + total_x2;
    assign total_x4    = {total_reg[TOTAL_W-3:0], 2'b00};

    always_comb
    begin
        state_next = state_reg;
        n_next     = n_reg;
        p_next     = p_reg;
        cube_next  = cube_reg;
        d1_next    = d1_reg;
        e1_next    = e1_reg;
        exp_next   = exp_reg;
        total_next = total_reg;
        flag_next  = flag_reg;
        idx_next   = idx_reg;
        d_next     = d_reg;
        s_next     = s_reg;
        x_next     = x_reg;
        bit_next   = bit_reg;
        rcnt_next  = rcnt_reg;
        alu_req    = '{start: 1'b0, op: ALU_DIV};
        alu_a      = n_reg;
        alu_b      = NUM_WIDTH'(p_reg);
        alu_m      = n_reg;
        in_ready   = 1'b0;
        res_valid  = 1'b0;

        unique case (state_reg)
            ST_IDLE:
            begin
                in_ready = 1'b1;
                if (in_valid)
                begin
                    n_next   = n_in;
                    p_next   = P_W'(2);
                    cube_next = CW'(8);
                    exp_next = '0;
                    if (LIMIT_W'(n_in) > upper_limit)
                    begin
                        flag_next  = 1'b1;
                        total_next = '0;
                        state_next = ST_DONE;
                    end
                    else if (n_in == '0)
                    begin
                        flag_next  = 1'b0;
                        total_next = '0;
                        state_next = ST_DONE;
                    end
                    else
                    begin
                        flag_next  = 1'b0;
                        total_next = TOTAL_W'(1);
                        state_next = ST_CHECK;
                    end
                end
            end
            ST_CHECK:
            begin
                if (cube_reg <= CW'(n_reg))
                    state_next = ST_TRIAL_ISSUE;
                else
                    state_next = ST_REM;
            end
            ST_TRIAL_ISSUE:
            begin
                alu_req    = '{start: 1'b1, op: ALU_DIV};
                state_next = ST_TRIAL_WAIT;
            end
            ST_TRIAL_WAIT:
            begin
                if (alu_done)
                begin
                    if (alu_r == '0)
                    begin
                        n_next     = alu_q;
                        exp_next   = exp_reg + EXP_W'(1);
                        state_next = ST_TRIAL_ISSUE;
                    end
                    else
                        state_next = ST_FOLD;
                end
            end
            ST_FOLD:
            begin
                total_next = TOTAL_W'(total_reg * fold_factor);
                exp_next   = '0;
                // cube advances by running differences: no multiplier needed
                if (p_reg == P_W'(2))
                begin
                    p_next    = P_W'(3);
                    cube_next = CW'(27);
                    d1_next   = CW'(98);
                    e1_next   = CW'(120);
                end
                else
                begin
                    p_next    = p_reg + P_W'(2);
                    cube_next = cube_reg + d1_reg;
                    d1_next   = d1_reg + e1_reg;
                    e1_next   = e1_reg + CW'(48);
                end
                state_next = ST_CHECK;
            end
            ST_REM:
            begin
                idx_next = '0;
                if (n_reg == NUM_WIDTH'(1))
                    state_next = ST_DONE;
                else
                    state_next = ST_BASE_CHECK;
            end
            ST_BASE_CHECK:
            begin
                if (n_reg == base_val)
                begin
                    total_next = total_x2;
                    state_next = ST_DONE;
                end
                else
                begin
                    alu_req    = '{start: 1'b1, op: ALU_DIV};
                    alu_b      = base_val;
                    state_next = ST_BASE_WAIT;
                end
            end
            ST_BASE_WAIT:
            begin
                if (alu_done)
                begin
                    if (alu_r == '0)
                        state_next = ST_SQRT_ISSUE;
                    else if (idx_reg == LAST_IDX)
                        state_next = ST_MR_SETUP;
                    else
                    begin
                        idx_next   = idx_reg + IDX_W'(1);
                        state_next = ST_BASE_CHECK;
                    end
                end
            end
            ST_MR_SETUP:
            begin
                d_next     = nm1;
                s_next     = '0;
                state_next = ST_MR_SHIFT;
            end
            ST_MR_SHIFT:
            begin
                if (!d_reg[0])
                begin
                    d_next = {1'b0, d_reg[NUM_WIDTH-1:1]};
                    s_next = s_reg + EXP_W'(1);
                end
                else
                begin
                    idx_next   = '0;
                    state_next = ST_MR_BASE;
                end
            end
            ST_MR_BASE:
            begin
                x_next     = NUM_WIDTH'(1);
                bit_next   = BIT_W'(NUM_WIDTH - 1);
                state_next = ST_MR_SQ;
            end
            ST_MR_SQ:
            begin
                alu_req    = '{start: 1'b1, op: ALU_MULMOD};
                alu_a      = x_reg;
                alu_b      = x_reg;
                state_next = ST_MR_SQ_WAIT;
            end
            ST_MR_SQ_WAIT:
            begin
                if (alu_done)
                begin
                    x_next     = alu_r;
                    state_next = ST_MR_MUL;
                end
            end
            ST_MR_MUL:
            begin
                if (d_reg[bit_reg])
                begin
                    alu_req    = '{start: 1'b1, op: ALU_MULMOD};
                    alu_a      = base_val;
                    alu_b      = x_reg;
                    state_next = ST_MR_MUL_WAIT;
                end
                else if (bit_reg == '0)
                    state_next = ST_MR_TEST;
                else
                begin
                    bit_next   = bit_reg - BIT_W'(1);
                    state_next = ST_MR_SQ;
                end
            end
            ST_MR_MUL_WAIT:
            begin
                if (alu_done)
                begin
                    x_next = alu_r;
                    if (bit_reg == '0)
                        state_next = ST_MR_TEST;
                    else
                    begin
                        bit_next   = bit_reg - BIT_W'(1);
                        state_next = ST_MR_SQ;
                    end
                end
            end
            ST_MR_TEST:
            begin
                if ((x_reg == NUM_WIDTH'(1)) || (x_reg == nm1))
                begin
                    if (idx_reg == LAST_IDX)
                    begin
                        total_next = total_x2;
                        state_next = ST_DONE;
                    end
                    else
                    begin
                        idx_next   = idx_reg + IDX_W'(1);
                        state_next = ST_MR_BASE;
                    end
                end
                else
                begin
                    rcnt_next  = EXP_W'(1);
                    state_next = ST_MR_LOOP;
                end
            end
            ST_MR_LOOP:
            begin
                if (rcnt_reg < s_reg)
                begin
                    alu_req    = '{start: 1'b1, op: ALU_MULMOD};
                    alu_a      = x_reg;
                    alu_b      = x_reg;
                    state_next = ST_MR_LOOP_WAIT;
                end
                else
                    state_next = ST_SQRT_ISSUE;
            end
            ST_MR_LOOP_WAIT:
            begin
                if (alu_done)
                begin
                    x_next = alu_r;
                    if (alu_r == nm1)
                    begin
                        if (idx_reg == LAST_IDX)
                        begin
                            total_next = total_x2;
                            state_next = ST_DONE;
                        end
                        else
                        begin
                            idx_next   = idx_reg + IDX_W'(1);
                            state_next = ST_MR_BASE;
                        end
                    end
                    else
                    begin
                        rcnt_next  = rcnt_reg + EXP_W'(1);
                        state_next = ST_MR_LOOP;
                    end
                end
            end
            ST_SQRT_ISSUE:
            begin
                alu_req    = '{start: 1'b1, op: ALU_SQRT};
                state_next = ST_SQRT_WAIT;
            end
            ST_SQRT_WAIT:
            begin
                if (alu_done)
                begin
                    // zero remainder: the cofactor is a prime squared
                    total_next = (alu_r == '0) ? total_x3 : total_x4;
                    state_next = ST_DONE;
                end
            end
            ST_DONE:
            begin
                res_valid = 1'b1;
                if (out_free)
                    state_next = ST_IDLE;
            end
            default: state_next = ST_IDLE;
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            state_reg <= ST_IDLE;
        else
            state_reg <= state_next;
    end

    always_ff @(posedge clk)
    begin
        n_reg     <= n_next;
        p_reg     <= p_next;
        cube_reg  <= cube_next;
        d1_reg    <= d1_next;
        e1_reg    <= e1_next;
        exp_reg   <= exp_next;
        total_reg <= total_next;
        flag_reg  <= flag_next;
        idx_reg   <= idx_next;
        d_reg     <= d_next;
        s_reg     <= s_next;
        x_reg     <= x_next;
        bit_reg   <= bit_next;
        rcnt_reg  <= rcnt_next;
    end

    assign res_total     = total_reg;
    assign res_too_large = flag_reg;

endmodule

`default_nettype wire

[rtl/divisor_count_trial.sv]
// ============================================================================
// divisor_count_trial: count the positive divisors of one unsigned number
// Stream in one number, stream out its divisor count and a too-large flag.
// ============================================================================
// Flow: a rejected or zero number goes to its result straight after the
//   range check. Otherwise restoring divisions in the shared unit by each
//   trial divisor (two, then the odd numbers) up to the cube root of n,
//   then the primality test by modular products in the shared unit and
//   the square test by a square root of the cofactor.
// Throughput: one number at a time; the next input beat is taken once the
//   result has moved into the output register.
// Reset: asynchronous, active low; upper_limit returns to 9999999999999999,
//   no clearing pass.
// ============================================================================
`default_nettype none

module divisor_count_trial #(
    parameter int NUM_WIDTH = dct_pkg::NUM_WIDTH_DEF
) (
    input  wire logic                             clk,
    input  wire logic                             rst_n,
    // slave side
    input  wire logic                             s_axis_tvalid,
    output logic                                  s_axis_tready,
    input  wire logic [dct_pkg::IN_W-1:0]         s_axis_tdata,  // [63:0] number_in
    // master side
    output logic                                  m_axis_tvalid,
    input  wire logic                             m_axis_tready,
    output logic [dct_pkg::OUT_TDATA_W-1:0]       m_axis_tdata,  // [16:0] divisor_total
    output logic                                  m_axis_tuser,  // [0] too_large
    // configuration write channel: upper_limit
    input  wire logic                             cfg_valid,
    output logic                                  cfg_ready,
    input  wire logic [dct_pkg::LIMIT_W-1:0]      cfg_data
);
    import dct_pkg::*;

    logic [LIMIT_W-1:0]   limit_reg;

    logic                 out_valid_reg;
    logic [TOTAL_W-1:0]   out_total_reg;
    logic                 out_flag_reg;
    logic                 out_free;

    logic                 res_valid;
    logic [TOTAL_W-1:0]   res_total;
    logic                 res_too_large;

    alu_req_t             alu_req;
    logic [NUM_WIDTH-1:0] alu_a;
    logic [NUM_WIDTH-1:0] alu_b;
    logic [NUM_WIDTH-1:0] alu_m;
    logic                 alu_done;
    logic [NUM_WIDTH-1:0] alu_q;
    logic [NUM_WIDTH-1:0] alu_r;

    // Configuration is always accepted; the limit is to be written only while
    // the block is idle (the block does not enforce this), so no shadowing is needed.
    assign cfg_ready = 1'b1;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            limit_reg <= LIMIT_RESET;
        else if (cfg_valid)
            limit_reg <= cfg_data;
    end

    // Output register: the sequencer parks in its done state until this
    // slot is empty or being drained in the same cycle.
    assign out_free = !out_valid_reg || m_axis_tready;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            out_valid_reg <= 1'b0;
        else if (res_valid && out_free)
            out_valid_reg <= 1'b1;
        else if (m_axis_tready)
            out_valid_reg <= 1'b0;
    end

    // Payload: load a finished beat, hold it while stalled.
    always_ff @(posedge clk)
    begin
        if (res_valid && out_free)
        begin
            out_total_reg <= res_total;
            out_flag_reg  <= res_too_large;
        end
    end

    assign m_axis_tvalid = out_valid_reg;
    assign m_axis_tdata  = OUT_TDATA_W'(out_total_reg);
    assign m_axis_tuser  = out_flag_reg;

    // Sequencer: range check, trial division, cofactor classification.
    dct_ctrl #(
        .NUM_WIDTH (NUM_WIDTH)
    ) u_ctrl (
        .clk           (clk),
        .rst_n         (rst_n),
        .in_valid      (s_axis_tvalid),
        .in_ready      (s_axis_tready),
        .number        (s_axis_tdata),
        .upper_limit   (limit_reg),
        .res_valid     (res_valid),
        .out_free      (out_free),
        .res_total     (res_total),
        .res_too_large (res_too_large),
        .alu_req       (alu_req),
        .alu_a         (alu_a),
        .alu_b         (alu_b),
        .alu_m         (alu_m),
        .alu_done      (alu_done),
        .alu_q         (alu_q),
        .alu_r         (alu_r)
    );

    // Shared unit: every division, modular product and square root of the
    // flow goes through this one compare-and-subtract datapath.
    dct_alu #(
        .NUM_WIDTH (NUM_WIDTH)
    ) u_alu (
        .clk   (clk),
        .rst_n (rst_n),
        .req   (alu_req),
        .opa   (alu_a),
        .opb   (alu_b),
        .opm   (alu_m),
        .done  (alu_done),
        .res_q (alu_q),
        .res_r (alu_r)
    );

endmodule

`default_nettype wire

[rtl/dct_checker.sv]
// ============================================================================
// dct_checker: port-level checks of the divisor counter
// Watches the stream and handshake ports over time; attached by bind.
// ============================================================================
`default_nettype none

module dct_checker (
    input wire logic                             clk,
    input wire logic                             rst_n,
    input wire logic                             s_axis_tvalid,
    input wire logic                             s_axis_tready,
    input wire logic [dct_pkg::IN_W-1:0]         s_axis_tdata,
    input wire logic                             m_axis_tvalid,
    input wire logic                             m_axis_tready,
    input wire logic [dct_pkg::OUT_TDATA_W-1:0]  m_axis_tdata,
    input wire logic                             m_axis_tuser,
    input wire logic                             cfg_valid,
    input wire logic                             cfg_ready,
    input wire logic [dct_pkg::LIMIT_W-1:0]      cfg_data
);
    import dct_pkg::*;

    // A flagged beat never carries a count.
    a_flag_zero_count: assert property (@(posedge clk) disable iff (!rst_n)
        m_axis_tvalid && m_axis_tuser |-> (m_axis_tdata[TOTAL_W-1:0] == '0))
        else $error("too-large beat with nonzero count");

    // One number at a time: after an input beat the slave side closes.
    a_busy_after_accept: assert property (@(posedge clk) disable iff (!rst_n)
        s_axis_tvalid && s_axis_tready |=> !s_axis_tready)
        else $error("input taken while a number is in progress");

    // A new result appears only after the block was working on a number.
    a_result_from_work: assert property (@(posedge clk) disable iff (!rst_n)
        $rose(m_axis_tvalid) |-> !$past(s_axis_tready))
        else $error("result beat without work in progress");

    // A stalled result beat holds.
    a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
        m_axis_tvalid && !m_axis_tready |=>
            m_axis_tvalid && $stable(m_axis_tdata) && $stable(m_axis_tuser))
        else $error("stalled result beat changed");

endmodule

bind divisor_count_trial dct_checker u_checker (.*);

`default_nettype wire

[verif/divisor_count_checker.sv]
`timescale 1ns / 1ps
// ============================================================================
// divisor_count_checker: result predictor and comparator for the divisor counter
// Watches the number, result and limit channels, predicts the divisor count
// and too-large flag of every accepted number, and compares each result beat
// with the oldest prediction.
// ============================================================================

module divisor_count_checker #(
    parameter int NUM_WIDTH = 64
) (
    input  logic                               clk,
    input  logic                               rst_n,
    input  logic                               s_axis_tvalid,
    input  logic                               s_axis_tready,
    input  logic [dct_pkg::IN_W-1:0]           s_axis_tdata,
    input  logic                               m_axis_tvalid,
    input  logic                               m_axis_tready,
    input  logic [dct_pkg::OUT_TDATA_W-1:0]    m_axis_tdata,
    input  logic                               m_axis_tuser,
    input  logic                               cfg_valid,
    input  logic                               cfg_ready,
    input  logic [dct_pkg::LIMIT_W-1:0]        cfg_data,
    output int                                 mismatches,
    output int                                 outstanding
);

    localparam logic [63:0] NUM_MASK = {64{1'b1}} >> (64 - NUM_WIDTH);

    typedef struct packed {
        logic [63:0]                  number;
        logic [dct_pkg::TOTAL_W-1:0]  total;
        logic                         too_large;
    } divisor_result_t;

    divisor_result_t             expected_results[$];
    divisor_result_t             want;
    logic [dct_pkg::LIMIT_W-1:0] limit_copy = dct_pkg::LIMIT_RESET;
    logic [dct_pkg::TOTAL_W-1:0] got_total;
    int                          errors = 0;

    function automatic logic [63:0] witness(int idx);
        case (idx)
            0:       return 64'd2;
            1:       return 64'd3;
            2:       return 64'd5;
            3:       return 64'd7;
            4:       return 64'd11;
            5:       return 64'd13;
            6:       return 64'd17;
            7:       return 64'd19;
            8:       return 64'd23;
            9:       return 64'd29;
            10:      return 64'd31;
            default: return 64'd37;
        endcase
    endfunction

    function automatic logic [63:0] mod_mul(logic [63:0] a, logic [63:0] b, logic [63:0] m);
        logic [127:0] prod;
        prod = ({64'd0, a} * {64'd0, b}) % {64'd0, m};
        return prod[63:0];
    endfunction

    function automatic logic [63:0] mod_pow(logic [63:0] b, logic [63:0] e, logic [63:0] m);
        logic [63:0] acc;
        acc = 64'd1 % m;
        b   = b % m;
        while (e != 0)
        begin
            if (e[0])
                acc = mod_mul(acc, b, m);
            b = mod_mul(b, b, m);
            e = e >> 1;
        end
        return acc;
    endfunction

    // Strong probable-prime test; the twelve smallest prime witnesses settle
    // every 64-bit number.
    function automatic bit is_prime_u64(logic [63:0] n);
        logic [63:0] d;
        logic [63:0] x;
        int          s;
        int          i;
        int          r;
        bit          ok;
        if (n < 2)
            return 1'b0;
        for (i = 0; i < 12; i++)
        begin
            if (n == witness(i))
                return 1'b1;
            if (n % witness(i) == 0)
                return 1'b0;
        end
        d = n - 1;
        s = 0;
        while (d[0] == 1'b0)
        begin
            d = d >> 1;
            s++;
        end
        for (i = 0; i < 12; i++)
        begin
            x  = mod_pow(witness(i), d, n);
            ok = (x == 1) || (x == n - 1);
            for (r = 1; r < s && !ok; r++)
            begin
                x = mod_mul(x, x, n);
                if (x == n - 1)
                    ok = 1'b1;
            end
            if (!ok)
                return 1'b0;
        end
        return 1'b1;
    endfunction

    function automatic logic [63:0] floor_root(logic [63:0] m);
        logic [63:0] lo;
        logic [63:0] hi;
        logic [63:0] mid;
        lo = 64'd0;
        hi = 64'hFFFF_FFFF;
        while (lo < hi)
        begin
            mid = lo + (hi - lo + 1) / 2;
            if (mid <= m / mid)
                lo = mid;
            else
                hi = mid - 1;
        end
        return lo;
    endfunction

    // Factor out candidates up to the cube root, then classify the cofactor:
    // one prime, the square of a prime, or two distinct primes.
    function automatic logic [dct_pkg::TOTAL_W-1:0] divisor_count_of(logic [63:0] n);
        logic [63:0] total;
        logic [63:0] p;
        logic [63:0] e;
        logic [63:0] root;
        if (n == 0)
            return '0;
        total = 64'd1;
        p     = 64'd2;
        while (p <= n / p / p)
        begin
            if (n % p == 0)
            begin
                e = 0;
                while (n % p == 0)
                begin
                    n = n / p;
                    e++;
                end
                total = total * (e + 1);
            end
            p = (p == 2) ? 64'd3 : p + 2;
        end
        if (n != 1)
        begin
            root = floor_root(n);
            if (is_prime_u64(n))
                total = total * 2;
            else if (root * root == n)
                total = total * 3;
            else
                total = total * 4;
        end
        return total[dct_pkg::TOTAL_W-1:0];
    endfunction

    function automatic divisor_result_t predict_result(logic [63:0] raw,
                                                       logic [63:0] limit);
        divisor_result_t res;
        res.number    = raw & NUM_MASK;
        res.too_large = (res.number > limit);
        res.total     = res.too_large ? '0 : divisor_count_of(res.number);
        return res;
    endfunction

    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            limit_copy = dct_pkg::LIMIT_RESET;
            expected_results.delete();
            outstanding <= 0;
            mismatches  <= 0;
        end
        else
        begin
            if (m_axis_tvalid && m_axis_tready)
            begin
                got_total = m_axis_tdata[dct_pkg::TOTAL_W-1:0];
                if (expected_results.size() == 0)
                begin
                    $display("%0t unexpected result: divisor_total %0d too_large %0d",
                             $time, got_total, m_axis_tuser);
                    errors++;
                end
                else
                begin
                    want = expected_results.pop_front();
                    if (got_total !== want.total)
                    begin
                        $display("%0t divisor_total of %0d: expected %0d, actual %0d",
                                 $time, want.number, want.total, got_total);
                        errors++;
                    end
                    if (m_axis_tuser !== want.too_large)
                    begin
                        $display("%0t too_large of %0d: expected %0d, actual %0d",
                                 $time, want.number, want.too_large, m_axis_tuser);
                        errors++;
                    end
                end
            end
            if (s_axis_tvalid && s_axis_tready)
                expected_results.push_back(predict_result(s_axis_tdata, limit_copy));
            if (cfg_valid && cfg_ready)
                limit_copy = cfg_data;
            outstanding <= expected_results.size();
            mismatches  <= errors;
        end
    end

endmodule

[verif/testbench.sv]
`timescale 1ns / 1ps
// ============================================================================
// testbench: stimulus and verdict for the divisor counter
// Feeds directed and random numbers under several limit settings and idle
// patterns, including a long result stall; the checker beside the block
// predicts every result and counts mismatches.
// ============================================================================

module testbench;

    localparam int  NUM_WIDTH   = 64;
    localparam int  CYCLE_LIMIT = 100_000_000;
    localparam int  STALL_LEN   = 600_000;
    localparam logic [63:0] ALL_ONES = {64{1'b1}};

    logic clk   = 1'b0;
    logic rst_n = 1'b0;

    logic                             s_axis_tvalid = 1'b0;
    logic                             s_axis_tready;
    logic [dct_pkg::IN_W-1:0]         s_axis_tdata  = '0;  // [63:0] number_in
    logic                             m_axis_tvalid;
    logic                             m_axis_tready = 1'b0;
    logic [dct_pkg::OUT_TDATA_W-1:0]  m_axis_tdata;        // [16:0] divisor_total
    logic                             m_axis_tuser;        // [0] too_large
    logic                             cfg_valid     = 1'b0;
    logic                             cfg_ready;
    logic [dct_pkg::LIMIT_W-1:0]      cfg_data      = '0;

    int mismatches;
    int outstanding;

    // idle rates in percent; the receiver rate is read by its own process
    int tx_idle_pct = 20;
    int rx_idle_pct = 78;

    logic        stall_request = 1'b0;
    logic        stall_taken   = 1'b0;
    int          stall_left    = 0;
    int          cycle_count   = 0;
    logic [63:0] limit_now     = dct_pkg::LIMIT_RESET;

    always
    begin
        #5 clk = 1'b1;
        #5 clk = 1'b0;
    end

    divisor_count_trial #(
        .NUM_WIDTH(NUM_WIDTH)
    ) dut (
        .clk           (clk),
        .rst_n         (rst_n),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .s_axis_tdata  (s_axis_tdata),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata),
        .m_axis_tuser  (m_axis_tuser),
        .cfg_valid     (cfg_valid),
        .cfg_ready     (cfg_ready),
        .cfg_data      (cfg_data)
    );

    divisor_count_checker #(
        .NUM_WIDTH(NUM_WIDTH)
    ) count_check (
        .clk           (clk),
        .rst_n         (rst_n),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .s_axis_tdata  (s_axis_tdata),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata),
        .m_axis_tuser  (m_axis_tuser),
        .cfg_valid     (cfg_valid),
        .cfg_ready     (cfg_ready),
        .cfg_data      (cfg_data),
        .mismatches    (mismatches),
        .outstanding   (outstanding)
    );

    // Result side: drop tready at the current idle rate, except during the
    // one long hold-off, which is counted here so the block backs up and
    // stalls its number input while the sender keeps offering.
    always @(posedge clk)
    begin
        if (!rst_n)
        begin
            m_axis_tready <= 1'b0;
            stall_left    <= 0;
        end
        else if (stall_left != 0)
        begin
            m_axis_tready <= 1'b0;
            stall_left    <= stall_left - 1;
        end
        else if (stall_request && !stall_taken)
        begin
            stall_taken   <= 1'b1;
            stall_left    <= STALL_LEN;
            m_axis_tready <= 1'b0;
        end
        else
        begin
            m_axis_tready <= ($urandom_range(99) >= rx_idle_pct);
        end
    end

    // Watchdog: end the run with an error once the cycle limit is reached.
    always @(posedge clk)
    begin
        cycle_count <= cycle_count + 1;
        if (cycle_count == CYCLE_LIMIT)
        begin
            $display("[divisor_count_trial] ERROR");
            $finish;
        end
    end

    function automatic logic [63:0] small_prime(int idx);
        case (idx)
            0:       return 64'd2;
            1:       return 64'd3;
            2:       return 64'd5;
            3:       return 64'd7;
            4:       return 64'd11;
            5:       return 64'd13;
            6:       return 64'd17;
            7:       return 64'd19;
            8:       return 64'd23;
            9:       return 64'd29;
            10:      return 64'd31;
            11:      return 64'd37;
            12:      return 64'd41;
            13:      return 64'd43;
            default: return 64'd47;
        endcase
    endfunction

    function automatic logic [63:0] prime_at_or_above(int start);
        logic [63:0] cand;
        int          f;
        bit          found;
        cand = start | 1;
        forever
        begin
            found = 1'b1;
            for (f = 3; f * f <= cand; f += 2)
                if (cand % f == 0)
                    found = 1'b0;
            if (found)
                return cand;
            cand += 2;
        end
    endfunction

    // Pick one number. Accepted numbers keep their cofactor small so the
    // block's trial division and primality test stay short; numbers above
    // the limit are drawn over the whole remaining range.
    function automatic logic [63:0] draw_number(logic [63:0] limit);
        logic [63:0] val;
        logic [63:0] p;
        logic [63:0] q;
        int          kind;
        int          k;
        kind = $urandom_range(99);
        if (kind >= 70 && limit != ALL_ONES)
        begin
            // anything above the limit: rejected by the range check
            val = limit + 1 + ({$urandom, $urandom} % (ALL_ONES - limit));
        end
        else if (kind < 30)
        begin
            val = $urandom_range(0, 1023);
        end
        else if (kind < 55 || kind >= 70)
        begin
            // smooth number, skewed toward the smallest primes, up to 64 bits
            val = 64'd1;
            for (k = $urandom_range(1, 40); k > 0; k--)
            begin
                p = small_prime($urandom_range(0, $urandom_range(0, 14)));
                if (val <= ALL_ONES / p)
                    val = val * p;
            end
        end
        else
        begin
            // cofactor cases: a prime, a prime square, two primes that may coincide
            p = prime_at_or_above($urandom_range(41, 400));
            q = prime_at_or_above($urandom_range(41, 400));
            case ($urandom_range(2))
                0:       val = p;
                1:       val = p * p;
                default: val = p * q;
            endcase
            val = val << $urandom_range(0, 3);
        end
        return val;
    endfunction

    // Offer one number and hold it until the block takes the beat.
    task automatic offer_number(input logic [63:0] value);
        while ($urandom_range(99) < tx_idle_pct)
        begin
            s_axis_tvalid <= 1'b0;
            @(posedge clk);
        end
        s_axis_tvalid <= 1'b1;
        s_axis_tdata  <= value;
        do
            @(posedge clk);
        while (!s_axis_tready);
    endtask

    // Drop valid, then wait until every predicted result has been taken and
    // the block has had time to go idle.
    task automatic drain_results();
        s_axis_tvalid <= 1'b0;
        @(posedge clk);
        while (outstanding != 0)
            @(posedge clk);
        repeat (8) @(posedge clk);
    endtask

    task automatic load_upper_limit(input logic [63:0] value);
        cfg_valid <= 1'b1;
        cfg_data  <= value;
        do
            @(posedge clk);
        while (!cfg_ready);
        cfg_valid <= 1'b0;
        limit_now = value;
    endtask

    task automatic random_numbers(input int count);
        int n;
        for (n = 0; n < count; n++)
            offer_number(draw_number(limit_now));
    endtask

    initial
    begin
        repeat (9) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // --- directed, limit at its reset value ---
        offer_number(64'd0);                  // zero: count of zero, accepted
        offer_number(64'd1);                  // one: single divisor
        offer_number(64'd2);
        offer_number(64'd4);                  // cofactor is a prime square
        offer_number(64'd6);                  // cofactor is two distinct primes
        offer_number(64'd97);                 // prime past every witness
        offer_number(64'd1849);               // square of a prime above the witnesses
        offer_number(64'd720720);
        offer_number(64'd9999999999999999);   // exactly the limit: accepted
        offer_number(64'd10000000000000000);  // one above: rejected
        offer_number(64'h8000_0000_0000_0000);
        offer_number(ALL_ONES);
        drain_results();

        // --- directed, widest limit ---
        load_upper_limit(ALL_ONES);
        offer_number(64'd897612484786617600); // largest count a 64-bit number has
        offer_number(64'h8000_0000_0000_0000);
        offer_number(64'd4294967296 * 64'd3486784401);
        drain_results();

        // --- directed, zero limit: only zero gets through ---
        load_upper_limit(64'd0);
        offer_number(64'd0);
        offer_number(64'd1);
        offer_number(ALL_ONES);
        drain_results();

        // --- random, sender idles lightly, receiver heavily ---
        load_upper_limit({32'd0, $urandom_range(32'h0000_1000, 32'h4000_0000)});
        random_numbers(28);
        drain_results();

        // --- random, roles swapped ---
        tx_idle_pct = 78;
        rx_idle_pct <= 20;
        load_upper_limit(ALL_ONES);
        random_numbers(28);
        drain_results();

        // --- random, no idling, with one long result hold-off up front ---
        tx_idle_pct = 0;
        rx_idle_pct <= 0;
        load_upper_limit({$urandom, $urandom});
        stall_request <= 1'b1;
        random_numbers(28);
        drain_results();

        if (mismatches == 0 && outstanding == 0)
            $display("[divisor_count_trial] OK");
        else
            $display("[divisor_count_trial] ERROR");
        $finish;
    end

endmodule
